>>> rtl/mscc_pkg.sv
// Shared widths, codes and state encoding for the max segment cut counter.
package mscc_pkg;

	localparam int LEN_W   = 10;
	localparam int CNT_W   = 11;
	localparam int MAX_LEN = 1024;
	localparam int ADDR_W  = $clog2(MAX_LEN);
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0] UNREACH = '1;
	localparam logic [LEN_W-1:0] PIECE_LEN_RESET = LEN_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PIECE_LEN_A = 2'd0,
		CFG_PIECE_LEN_B = 2'd1,
		CFG_PIECE_LEN_C = 2'd2
	} cfg_index_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_INIT = 7'b0000010,
		ST_RDA  = 7'b0000100,
		ST_RDB  = 7'b0001000,
		ST_RDC  = 7'b0010000,
		ST_WR   = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

endpackage

>>> rtl/mscc_len_if.sv
// Valid/ready channel that carries one rod length per beat.
interface mscc_len_if
	import mscc_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] total_len;

	modport source (output valid, output total_len, input ready);
	modport sink   (input valid, input total_len, output ready);
endinterface

>>> rtl/mscc_cnt_if.sv
// Valid/ready channel that carries one piece count per beat.
interface mscc_cnt_if
	import mscc_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] max_pieces;

	modport source (output valid, output max_pieces, input ready);
	modport sink   (input valid, input max_pieces, output ready);
endinterface

>>> rtl/max_segment_cut_count_top.sv
// Top level of the max segment cut counter: sequencer, shared compare unit and table memory.
//
// Usage: each input beat on in_ch carries a rod length total_len. The block
// returns on out_ch one beat with max_pieces, the largest number of pieces of
// the three configured lengths that add up exactly to total_len, or 0 if no
// exact cut exists or the length is zero.
// The piece lengths must be written through cfg_we/cfg_index/cfg_data only while
// the block is idle; the block itself does not enforce this. They reset to 1.
// Sequence: an accepted length n goes through the init state, which writes
// entry zero, n length steps and the finish state, which loads the result into
// the output register (n = 0 goes from init to finish). Each length step issues
// three reads and one write on the single port of the 1024-entry table memory;
// one increment-and-compare unit is shared by the three candidates. in_ch.ready
// is high only in the idle state, so one item is in work at a time; the next
// length can be accepted in the cycle after a result is loaded.
// The output register holds a finished result while the receiver stalls; the
// next item may be accepted meanwhile, and its result waits for the slot.
// Reset clears the sequencer and the output valid and sets the piece lengths to 1.
// The table needs no clearing: each item rewrites entry zero first and every
// entry whose read data is used has been written earlier for the same item.
module max_segment_cut_count_top
	import mscc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEN_W-1:0]     cfg_data,
	mscc_len_if.sink             in_ch,
	mscc_cnt_if.source           out_ch
);

	state_t            state_q, state_d;
	logic [LEN_W-1:0]  piece_a_q, piece_b_q, piece_c_q;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] idx_q;
	logic [CNT_W-1:0]  best_q;
	logic [CNT_W-1:0]  rd_q;
	logic [LEN_W-1:0]  res_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  mem [MAX_LEN];

	logic [LEN_W-1:0]  rd_piece, ev_piece;
	logic              ev_ok;
	logic [CNT_W-1:0]  cand, best_next;
	logic [ADDR_W-1:0] mem_addr;
	logic              mem_we;
	logic [CNT_W-1:0]  mem_wdata;
	logic              accept, out_load;

	assign accept   = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ch.ready);

	// Piece whose table entry is read this cycle.
	always_comb begin
		case (state_q)
			ST_RDA:  rd_piece = piece_a_q;
			ST_RDB:  rd_piece = piece_b_q;
			default: rd_piece = piece_c_q;
		endcase
	end

	// Piece whose read data arrives this cycle and is evaluated.
	always_comb begin
		case (state_q)
			ST_RDB:  ev_piece = piece_a_q;
			ST_RDC:  ev_piece = piece_b_q;
			default: ev_piece = piece_c_q;
		endcase
	end

	// Shared unit: a piece counts if it is nonzero, fits and lands on a reachable entry.
	always_comb begin
		ev_ok = (ev_piece != '0) && (ev_piece <= idx_q) && (rd_q != UNREACH);
		cand  = rd_q + CNT_W'(1);
		best_next = best_q;
		if (ev_ok && ((best_q == UNREACH) || (cand > best_q))) begin
			best_next = cand;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = best_next;
		mem_addr  = idx_q - rd_piece;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = '0;
				mem_addr  = '0;
			end
			ST_WR: begin
				mem_we   = 1'b1;
				mem_addr = idx_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_q <= mem[mem_addr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_INIT;
			ST_INIT: state_d = (len_q == '0) ? ST_FIN : ST_RDA;
			ST_RDA:  state_d = ST_RDB;
			ST_RDB:  state_d = ST_RDC;
			ST_RDC:  state_d = ST_WR;
			ST_WR:   state_d = (idx_q == len_q) ? ST_FIN : ST_RDA;
			ST_FIN:  if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			piece_a_q   <= PIECE_LEN_RESET;
			piece_b_q   <= PIECE_LEN_RESET;
			piece_c_q   <= PIECE_LEN_RESET;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_PIECE_LEN_A: piece_a_q <= cfg_data;
					CFG_PIECE_LEN_B: piece_b_q <= cfg_data;
					CFG_PIECE_LEN_C: piece_c_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			len_q <= in_ch.total_len;
		end
		case (state_q)
			ST_INIT: begin
				idx_q  <= ADDR_W'(1);
				best_q <= UNREACH;
				res_q  <= '0;
			end
			ST_RDB, ST_RDC: best_q <= best_next;
			ST_WR: begin
				idx_q  <= idx_q + ADDR_W'(1);
				best_q <= UNREACH;
				// The last step's best becomes the answer; unreachable reads as zero.
				res_q  <= (best_next == UNREACH) ? '0 : best_next[LEN_W-1:0];
			end
			default: ;
		endcase
		if (out_load) begin
			out_ch.max_pieces <= res_q;
		end
	end

	assign out_ch.valid = out_valid_q;

endmodule
